// ===== rtl/core/lbsp_pkg.sv =====
// Shared constants, types and the band edge table of the log-band peak core.
`default_nettype none

package lbsp_pkg;

    localparam int NUM_BANDS   = 100;
    localparam int NUM_BINS    = 1024;
    localparam int BIN_W       = 10;
    localparam int BAND_W      = 7;
    localparam int MAG_W       = 16;
    localparam int GAIN_W      = 16;
    localparam int OFF_W       = 8;
    localparam int CAP_W       = 16;
    localparam int HEIGHT_W    = 17;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int PROD_W      = MAG_W + GAIN_W;
    localparam int RAD_W       = PROD_W + GAIN_W;
    localparam int ROOT_W      = RAD_W / 2;
    localparam int REM_W       = ROOT_W + 2;
    localparam int STEP_W      = 5;
    localparam int Y_W         = HEIGHT_W + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [GAIN_W-1:0] GAIN_RESET   = 16'd3060;
    localparam logic [OFF_W-1:0]  OFFSET_RESET = 8'd4;
    localparam logic [CAP_W-1:0]  CAP_RESET    = 16'd1020;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_GAIN   = 2'd0,
        CFG_OFFSET = 2'd1,
        CFG_CAP    = 2'd2
    } t_cfg_reg;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL1,
        BK_MUL2,
        BK_ROOT,
        BK_FIN,
        BK_DONE
    } t_back_state;

    // one closed band on its way from the front to the back
    typedef struct packed {
        logic [BAND_W-1:0] band;
        logic [MAG_W-1:0]  peak;
        logic              last;
    } t_job;

    // last bin of each band; the low bands are one bin wide
    function automatic logic [BIN_W-1:0] band_end(input logic [BAND_W-1:0] band);
        logic [BIN_W-1:0] e;
        begin
            e = {{(BIN_W-BAND_W){1'b0}}, band} + BIN_W'(1);
            case (band)
                7'd59: e = 10'd62;
                7'd60: e = 10'd66;
                7'd61: e = 10'd71;
                7'd62: e = 10'd76;
                7'd63: e = 10'd82;
                7'd64: e = 10'd88;
                7'd65: e = 10'd94;
                7'd66: e = 10'd101;
                7'd67: e = 10'd108;
                7'd68: e = 10'd116;
                7'd69: e = 10'd125;
                7'd70: e = 10'd134;
                7'd71: e = 10'd144;
                7'd72: e = 10'd154;
                7'd73: e = 10'd165;
                7'd74: e = 10'd177;
                7'd75: e = 10'd190;
                7'd76: e = 10'd204;
                7'd77: e = 10'd219;
                7'd78: e = 10'd235;
                7'd79: e = 10'd252;
                7'd80: e = 10'd270;
                7'd81: e = 10'd290;
                7'd82: e = 10'd311;
                7'd83: e = 10'd334;
                7'd84: e = 10'd358;
                7'd85: e = 10'd384;
                7'd86: e = 10'd412;
                7'd87: e = 10'd441;
                7'd88: e = 10'd474;
                7'd89: e = 10'd508;
                7'd90: e = 10'd545;
                7'd91: e = 10'd584;
                7'd92: e = 10'd627;
                7'd93: e = 10'd672;
                7'd94: e = 10'd721;
                7'd95: e = 10'd773;
                7'd96: e = 10'd830;
                7'd97: e = 10'd890;
                7'd98: e = 10'd954;
                7'd99: e = 10'd1023;
                default: ;
            endcase
            return e;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lbsp_front.sv =====
// Front end: bin and band counting, running peak, band close detection.
`default_nettype none

module lbsp_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_accept,
    input  wire logic [lbsp_pkg::MAG_W-1:0] i_magnitude,
    input  wire logic                       i_frame_start,
    output logic                            o_job_push,
    output lbsp_pkg::t_job                  o_job
);

    logic [lbsp_pkg::BIN_W-1:0]  r_bin_cnt, n_bin_cnt;
    logic [lbsp_pkg::BAND_W-1:0] r_band_cnt, n_band_cnt;
    logic [lbsp_pkg::MAG_W-1:0]  r_peak, n_peak;
    logic [lbsp_pkg::BIN_W-1:0]  bin_k;
    logic [lbsp_pkg::MAG_W-1:0]  peak_max;
    logic                        band_close;

    always_comb begin
        // a frame start forces bin 0
        bin_k      = i_frame_start ? '0 : r_bin_cnt;
        peak_max   = (i_magnitude > r_peak) ? i_magnitude : r_peak;
        band_close = (r_band_cnt < lbsp_pkg::BAND_W'(lbsp_pkg::NUM_BANDS))
                     && (bin_k == lbsp_pkg::band_end(r_band_cnt));
        n_bin_cnt  = r_bin_cnt;
        n_band_cnt = r_band_cnt;
        n_peak     = r_peak;
        o_job_push = 1'b0;
        if (i_accept) begin
            n_bin_cnt = (bin_k == lbsp_pkg::BIN_W'(lbsp_pkg::NUM_BINS - 1)) ? '0
                        : bin_k + lbsp_pkg::BIN_W'(1);
            if (bin_k == '0) begin
                n_band_cnt = '0;
                n_peak     = '0;
            end else if (band_close) begin
                o_job_push = 1'b1;
                n_band_cnt = r_band_cnt + lbsp_pkg::BAND_W'(1);
                n_peak     = '0;
            end else begin
                n_peak = peak_max;
            end
        end
    end

    assign o_job.band = r_band_cnt;
    assign o_job.peak = peak_max;
    assign o_job.last = (r_band_cnt == lbsp_pkg::BAND_W'(lbsp_pkg::NUM_BANDS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_cnt  <= '0;
            r_band_cnt <= '0;
            r_peak     <= '0;
        end else begin
            r_bin_cnt  <= n_bin_cnt;
            r_band_cnt <= n_band_cnt;
            r_peak     <= n_peak;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/lbsp_queue.sv =====
// Short queue of closed bands between the front and the back.
`default_nettype none

module lbsp_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire lbsp_pkg::t_job i_job,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_valid,
    output lbsp_pkg::t_job      o_head
);

    lbsp_pkg::t_job              r_mem [lbsp_pkg::QUEUE_DEPTH];
    logic [lbsp_pkg::QPTR_W-1:0] r_wr, r_rd;
    logic [lbsp_pkg::QCNT_W-1:0] r_cnt;
    logic                        do_push, do_pop;

    assign o_full  = (r_cnt == lbsp_pkg::QCNT_W'(lbsp_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + lbsp_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + lbsp_pkg::QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + lbsp_pkg::QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - lbsp_pkg::QCNT_W'(1);
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/lbsp_back.sv =====
// Back end: peak times gain squared, bit-serial square root, offset, cap, result register.
`default_nettype none

module lbsp_back (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_job_valid,
    input  wire lbsp_pkg::t_job                       i_job,
    output logic                                      o_job_pop,
    input  wire logic [lbsp_pkg::GAIN_W-1:0]          i_gain,
    input  wire logic [lbsp_pkg::OFF_W-1:0]           i_offset,
    input  wire logic [lbsp_pkg::CAP_W-1:0]           i_cap,
    input  wire logic                                 i_pop,
    output logic                                      o_empty,
    output logic [lbsp_pkg::BAND_W-1:0]               o_band_index,
    output logic signed [lbsp_pkg::HEIGHT_W-1:0]      o_band_height,
    output logic                                      o_last_band
);

    lbsp_pkg::t_back_state              r_state, n_state;
    lbsp_pkg::t_job                     r_job;
    logic [lbsp_pkg::PROD_W-1:0]        r_prod;
    logic [lbsp_pkg::RAD_W-1:0]         r_rad;
    logic [lbsp_pkg::REM_W-1:0]         r_rem;
    logic [lbsp_pkg::ROOT_W-1:0]        r_root;
    logic [lbsp_pkg::STEP_W-1:0]        r_step;
    logic signed [lbsp_pkg::Y_W-1:0]    r_y;
    logic                               r_out_valid;
    logic [lbsp_pkg::BAND_W-1:0]        r_out_band;
    logic signed [lbsp_pkg::HEIGHT_W-1:0] r_out_height;
    logic                               r_out_last;

    logic                               out_load;
    logic                               root_last;
    logic [lbsp_pkg::RAD_W-1:0]         mul2;
    logic [lbsp_pkg::REM_W+1:0]         rem_t, trial, rem_sub;
    logic [lbsp_pkg::MAG_W-1:0]         root_int;
    logic                               exact;
    logic signed [lbsp_pkg::Y_W-1:0]    f_ext, off_ext, y_val, cap_ext;

    assign root_last = (r_step == lbsp_pkg::STEP_W'(lbsp_pkg::ROOT_W - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lbsp_pkg::BK_IDLE: if (i_job_valid) n_state = lbsp_pkg::BK_MUL1;
            lbsp_pkg::BK_MUL1: n_state = lbsp_pkg::BK_MUL2;
            lbsp_pkg::BK_MUL2: n_state = lbsp_pkg::BK_ROOT;
            lbsp_pkg::BK_ROOT: if (root_last) n_state = lbsp_pkg::BK_FIN;
            lbsp_pkg::BK_FIN:  n_state = lbsp_pkg::BK_DONE;
            lbsp_pkg::BK_DONE: if (!r_out_valid || i_pop) n_state = lbsp_pkg::BK_IDLE;
            default:           n_state = lbsp_pkg::BK_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_job_pop = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            lbsp_pkg::BK_IDLE: o_job_pop = i_job_valid;
            lbsp_pkg::BK_DONE: out_load  = !r_out_valid || i_pop;
            default: ;
        endcase
    end

    // datapath
    always_comb begin
        mul2     = lbsp_pkg::RAD_W'(r_prod) * lbsp_pkg::RAD_W'(i_gain);
        rem_t    = {r_rem, r_rad[lbsp_pkg::RAD_W-1 -: 2]};
        trial    = {2'b00, r_root, 2'b01};
        rem_sub  = rem_t - trial;
        root_int = r_root[lbsp_pkg::ROOT_W-1 -: lbsp_pkg::MAG_W];
        // the scaled root is an exact integer: truncation toward zero needs no bump
        exact    = (r_rem == '0) && (r_root[lbsp_pkg::ROOT_W-lbsp_pkg::MAG_W-1:0] == '0);
        f_ext    = $signed({2'b00, root_int});
        off_ext  = $signed({{(lbsp_pkg::Y_W-lbsp_pkg::OFF_W){1'b0}}, i_offset});
        cap_ext  = $signed({2'b00, i_cap});
        if (f_ext >= off_ext) begin
            y_val = f_ext - off_ext;
        end else if (exact) begin
            y_val = f_ext - off_ext;
        end else begin
            y_val = f_ext + lbsp_pkg::Y_W'(1) - off_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            lbsp_pkg::BK_IDLE: begin
                if (i_job_valid) begin
                    r_job <= i_job;
                end
            end
            lbsp_pkg::BK_MUL1: begin
                r_prod <= lbsp_pkg::PROD_W'(r_job.peak) * lbsp_pkg::PROD_W'(i_gain);
            end
            lbsp_pkg::BK_MUL2: begin
                r_rad  <= mul2;
                r_rem  <= '0;
                r_root <= '0;
                r_step <= '0;
            end
            lbsp_pkg::BK_ROOT: begin
                // one root bit per cycle from the top two radicand bits
                r_rad  <= r_rad << 2;
                r_step <= r_step + lbsp_pkg::STEP_W'(1);
                if (rem_t >= trial) begin
                    r_rem  <= rem_sub[lbsp_pkg::REM_W-1:0];
                    r_root <= {r_root[lbsp_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_t[lbsp_pkg::REM_W-1:0];
                    r_root <= {r_root[lbsp_pkg::ROOT_W-2:0], 1'b0};
                end
            end
            lbsp_pkg::BK_FIN: begin
                r_y <= y_val;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_band   <= r_job.band;
            r_out_last   <= r_job.last;
            r_out_height <= (r_y > cap_ext) ? $signed({1'b0, i_cap})
                                            : r_y[lbsp_pkg::HEIGHT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lbsp_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_band_index  = r_out_band;
    assign o_band_height = r_out_height;
    assign o_last_band   = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/core/log_band_spectrum_peaks_core.sv =====
// Top level of the log-band spectrum peak core: registers, front, queue and back.
//
//   channel   direction  handshake          payload
//   bins      in         push / full        i_magnitude, i_frame_start
//   bands     out        empty / pop        o_band_index, o_band_height, o_last_band
//   config    in         i_cfg_we           i_cfg_addr, i_cfg_wdata
//
// The front takes one bin per cycle while the queue is not full.
// A closed band goes through a four-entry queue to the back, which takes it through
// two multiplies, 24 steps of the bit-serial square root, offset and cap.
// full rises while the queue holds four bands; a waiting result that is not popped holds
// the back after it has finished the next band.
// Reset is synchronous and immediate; no clearing pass follows.
`default_nettype none

module log_band_spectrum_peaks_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic [lbsp_pkg::MAG_W-1:0]          i_magnitude,
    input  wire logic                                i_frame_start,
    output logic                                     empty,
    input  wire logic                                pop,
    output logic [lbsp_pkg::BAND_W-1:0]              o_band_index,
    output logic signed [lbsp_pkg::HEIGHT_W-1:0]     o_band_height,
    output logic                                     o_last_band,
    input  wire logic                                i_cfg_we,
    input  wire logic [lbsp_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  wire logic [lbsp_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    logic [lbsp_pkg::GAIN_W-1:0] r_gain;
    logic [lbsp_pkg::OFF_W-1:0]  r_offset;
    logic [lbsp_pkg::CAP_W-1:0]  r_cap;

    logic           accept;
    logic           job_push, job_pop, job_valid;
    lbsp_pkg::t_job job_in, job_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= lbsp_pkg::GAIN_RESET;
            r_offset <= lbsp_pkg::OFFSET_RESET;
            r_cap    <= lbsp_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            // drop bits above each register's width; ignore unknown indexes
            case (lbsp_pkg::t_cfg_reg'(i_cfg_addr))
                lbsp_pkg::CFG_GAIN:   r_gain   <= i_cfg_wdata[lbsp_pkg::GAIN_W-1:0];
                lbsp_pkg::CFG_OFFSET: r_offset <= i_cfg_wdata[lbsp_pkg::OFF_W-1:0];
                lbsp_pkg::CFG_CAP:    r_cap    <= i_cfg_wdata[lbsp_pkg::CAP_W-1:0];
                default: ;
            endcase
        end
    end

    assign accept = push && !full;

    lbsp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_magnitude   (i_magnitude),
        .i_frame_start (i_frame_start),
        .o_job_push    (job_push),
        .o_job         (job_in)
    );

    lbsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .i_pop   (job_pop),
        .o_full  (full),
        .o_valid (job_valid),
        .o_head  (job_head)
    );

    lbsp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (job_valid),
        .i_job         (job_head),
        .o_job_pop     (job_pop),
        .i_gain        (r_gain),
        .i_offset      (r_offset),
        .i_cap         (r_cap),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_band_index  (o_band_index),
        .o_band_height (o_band_height),
        .o_last_band   (o_last_band)
    );

endmodule

`default_nettype wire

// ===== rtl/core/lbsp_checker.sv =====
// Port-level checks of the log-band peak core, bound to the top level.
`default_nettype none

module lbsp_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                push,
    input wire logic                                full,
    input wire logic                                empty,
    input wire logic                                pop,
    input wire logic [lbsp_pkg::BAND_W-1:0]         o_band_index,
    input wire logic signed [lbsp_pkg::HEIGHT_W-1:0] o_band_height,
    input wire logic                                o_last_band
);

    // reset leaves no word waiting and room for bins
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("core not cleared by reset");

    // a word not popped stays put
    a_word_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_band_index) && $stable(o_band_height)
                           && $stable(o_last_band))
        else $error("waiting word changed before pop");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_last_band
                   == (o_band_index == lbsp_pkg::BAND_W'(lbsp_pkg::NUM_BANDS - 1)))
        else $error("last band flag disagrees with band index");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_band_index < lbsp_pkg::BAND_W'(lbsp_pkg::NUM_BANDS))
        else $error("band index out of range");

    // the offset is at most 255, so no height goes below its negative
    a_height_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_band_height >= -17'sd255)
        else $error("band height below minus the largest offset");

endmodule

bind log_band_spectrum_peaks_core lbsp_checker u_lbsp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .push          (push),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .o_band_index  (o_band_index),
    .o_band_height (o_band_height),
    .o_last_band   (o_last_band)
);

`default_nettype wire

// ===== tb/tb_log_band_spectrum_peaks_core.sv =====
// Self-checking testbench for the log-band spectrum peak core: bin stream in, band words out.
module tb_log_band_spectrum_peaks_core;

    localparam int BAND_COUNT = 100;
    localparam int BIN_COUNT  = 1024;
    localparam int DRAIN_GAP  = 64;
    localparam int PLAN_LEN   = 17;
    localparam logic [lbsp_pkg::CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [lbsp_pkg::BAND_W-1:0]   idx;
        logic [lbsp_pkg::HEIGHT_W-1:0] height;
        logic                          last;
    } t_band_word;

    typedef struct packed {
        logic [lbsp_pkg::MAG_W-1:0] mag;
        logic                       start;
        logic                       typed;
        t_band_word                 want;
    } t_bin_word;

    localparam t_band_word NO_BAND = '0;

    logic                                  i_clk = 1'b0;
    logic                                  i_rst_n = 1'b0;
    logic                                  push = 1'b0;
    logic                                  pop = 1'b0;
    logic [lbsp_pkg::MAG_W-1:0]            i_magnitude = '0;
    logic                                  i_frame_start = 1'b0;
    logic                                  i_cfg_we = 1'b0;
    logic [lbsp_pkg::CFG_ADDR_W-1:0]       i_cfg_addr = '0;
    logic [lbsp_pkg::CFG_DATA_W-1:0]       i_cfg_wdata = '0;
    logic                                  full;
    logic                                  empty;
    logic [lbsp_pkg::BAND_W-1:0]           o_band_index;
    logic signed [lbsp_pkg::HEIGHT_W-1:0]  o_band_height;
    logic                                  o_last_band;

    // band model state and register copies
    int unsigned                bin_pos = 0;
    int unsigned                band_pos = 0;
    logic [lbsp_pkg::MAG_W-1:0] band_peak = '0;
    logic [15:0]                gain_r = 16'd3060;
    logic [7:0]                 off_r = 8'd4;
    logic [15:0]                cap_r = 16'd1020;
    int unsigned                bin_stop [BAND_COUNT];

    t_bin_word  bin_q [$];
    t_band_word band_wait_q [$];
    t_bin_word  drv_word;
    t_band_word calc_w;
    t_band_word oldest_w;
    bit         has_band;
    int         send_idle_pct = 22;
    int         recv_idle_pct = 48;
    int         fault_count = 0;
    int         bins_sent = 0;
    int         bands_seen = 0;
    int         settings_done = 0;

    // directed words at reset register values (gain 3060, offset 4, cap 1020)
    t_bin_word plan [PLAN_LEN] = '{
        '{16'h0000, 1'b1, 1'b0, NO_BAND},
        '{16'h0000, 1'b0, 1'b1, '{7'd0, -17'sd4, 1'b0}},
        '{16'hFFFF, 1'b0, 1'b1, '{7'd1, 17'sd1020, 1'b0}},
        '{16'h0001, 1'b0, 1'b1, '{7'd2, 17'sd7, 1'b0}},
        '{16'hFFFF, 1'b1, 1'b0, NO_BAND},
        '{16'h0000, 1'b0, 1'b1, '{7'd0, -17'sd4, 1'b0}},
        '{16'hAAAA, 1'b0, 1'b0, NO_BAND},
        '{16'h5555, 1'b0, 1'b0, NO_BAND},
        '{16'h0010, 1'b0, 1'b1, '{7'd3, 17'sd43, 1'b0}},
        '{16'h0100, 1'b0, 1'b1, '{7'd4, 17'sd187, 1'b0}},
        '{16'h0004, 1'b0, 1'b1, '{7'd5, 17'sd19, 1'b0}},
        '{16'h0002, 1'b0, 1'b0, NO_BAND},
        '{16'h8000, 1'b0, 1'b0, NO_BAND},
        '{16'h7FFF, 1'b0, 1'b0, NO_BAND},
        '{16'h0000, 1'b1, 1'b0, NO_BAND},
        '{16'h0001, 1'b1, 1'b0, NO_BAND},
        '{16'h0000, 1'b0, 1'b1, '{7'd0, -17'sd4, 1'b0}}
    };

    log_band_spectrum_peaks_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_magnitude   (i_magnitude),
        .i_frame_start (i_frame_start),
        .empty         (empty),
        .pop           (pop),
        .o_band_index  (o_band_index),
        .o_band_height (o_band_height),
        .o_last_band   (o_last_band),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        fault_count++;
        if (fault_count <= 30)
            $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
    endtask

    function automatic logic [lbsp_pkg::HEIGHT_W-1:0] band_height_for(
            input logic [lbsp_pkg::MAG_W-1:0] peak);
        longint unsigned sq;
        longint unsigned root;
        longint unsigned trial;
        longint          whole;
        longint          y;
        int              i;
        sq = 64'(peak) * 64'(gain_r) * 64'(gain_r);
        root = 0;
        for (i = 24; i >= 0; i--) begin
            trial = root | (64'd1 << i);
            if (trial * trial <= sq)
                root = trial;
        end
        whole = longint'(root >> 8);
        if (whole >= longint'(off_r))
            y = whole - longint'(off_r);
        else if (root * root == sq && root[7:0] == 8'd0)
            y = whole - longint'(off_r);
        else
            // negative result truncates toward zero: round the scaled root up
            y = whole + 1 - longint'(off_r);
        if (y > longint'(cap_r))
            y = longint'(cap_r);
        return lbsp_pkg::HEIGHT_W'(y);
    endfunction

    // advance the band model by one bin; returns 1 when a band closes
    function automatic bit take_bin(input logic [lbsp_pkg::MAG_W-1:0] mag, input logic start,
                                    output t_band_word w);
        int unsigned k;
        k = start ? 0 : bin_pos;
        bin_pos = (k + 1 >= BIN_COUNT) ? 0 : k + 1;
        w = '0;
        if (k == 0) begin
            band_pos = 0;
            band_peak = '0;
            return 1'b0;
        end
        if (mag > band_peak)
            band_peak = mag;
        if (band_pos < BAND_COUNT && k == bin_stop[band_pos]) begin
            w.idx = lbsp_pkg::BAND_W'(band_pos);
            w.height = band_height_for(band_peak);
            w.last = (band_pos == BAND_COUNT - 1);
            band_pos++;
            band_peak = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [lbsp_pkg::MAG_W-1:0] rand_mag();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return lbsp_pkg::MAG_W'($urandom_range(0, 255));
            3: return lbsp_pkg::MAG_W'($urandom_range(0, 15));
            default: return lbsp_pkg::MAG_W'($urandom);
        endcase
    endfunction

    task automatic queue_bin(input logic [lbsp_pkg::MAG_W-1:0] mag, input logic start);
        t_bin_word w;
        w = '0;
        w.mag = mag;
        w.start = start;
        bin_q.push_back(w);
    endtask

    // called just after a rising edge; the write lands on the next one
    task automatic write_reg(input logic [lbsp_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [lbsp_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (idx)
            lbsp_pkg::CFG_GAIN:   gain_r = data;
            lbsp_pkg::CFG_OFFSET: off_r = data[7:0];
            lbsp_pkg::CFG_CAP:    cap_r = data;
            default: ;
        endcase
    endtask

    // the back still works through queued bands after the last word, so hold a while after it
    task automatic wait_for_drain();
        while (bin_q.size() != 0 || push || band_wait_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_GAP) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
            pop <= 1'b0;
        end else begin
            if (push && !full) begin
                has_band = take_bin(drv_word.mag, drv_word.start, calc_w);
                if (drv_word.typed)
                    band_wait_q.push_back(drv_word.want);
                else if (has_band)
                    band_wait_q.push_back(calc_w);
                bins_sent++;
            end
            // hold the word while the core is full
            if (!(push && full)) begin
                if (bin_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    drv_word = bin_q.pop_front();
                    push <= 1'b1;
                    i_magnitude <= drv_word.mag;
                    i_frame_start <= drv_word.start;
                end else begin
                    push <= 1'b0;
                    i_magnitude <= lbsp_pkg::MAG_W'($urandom);
                    i_frame_start <= 1'($urandom);
                end
            end
            if (pop && !empty) begin
                bands_seen++;
                if (band_wait_q.size() == 0) begin
                    flag_mismatch("band word with none pending, index", o_band_index, -1);
                end else begin
                    oldest_w = band_wait_q.pop_front();
                    if (o_band_index !== oldest_w.idx)
                        flag_mismatch("band index", o_band_index, oldest_w.idx);
                    if (o_band_height !== oldest_w.height)
                        flag_mismatch("band height", o_band_height, $signed(oldest_w.height));
                    if (o_last_band !== oldest_w.last)
                        flag_mismatch("last band", o_last_band, oldest_w.last);
                end
            end
            pop <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial begin
        int unsigned b;
        int unsigned k;
        int unsigned fl;
        int unsigned prev;
        int unsigned stop;
        int unsigned phase;
        int unsigned seg;
        int unsigned fed;
        int unsigned len;
        int unsigned kind;
        int unsigned j;
        bit [1199:0] acc;
        bit [1199:0] lim;

        // last bin: largest n with n^99 <= 2^(10b), capped at 1023 and kept above the last
        fl = 1;
        prev = 0;
        for (b = 0; b < BAND_COUNT; b++) begin
            lim = '0;
            lim[10 * b] = 1'b1;
            while (1) begin
                acc = 1;
                for (k = 0; k < BAND_COUNT - 1; k++)
                    acc = acc * (fl + 1);
                if (acc > lim)
                    break;
                fl++;
            end
            stop = (fl > BIN_COUNT - 1) ? BIN_COUNT - 1 : fl;
            if (stop <= prev)
                stop = prev + 1;
            bin_stop[b] = stop;
            prev = stop;
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (plan[r])
            bin_q.push_back(plan[r]);

        for (phase = 0; phase < 3; phase++) begin
            for (seg = phase * 3; seg < phase * 3 + 3; seg++) begin
                wait_for_drain();
                case (phase)
                    0: begin send_idle_pct = 22; recv_idle_pct = 48; end
                    1: begin send_idle_pct = 48; recv_idle_pct = 22; end
                    default: begin send_idle_pct = 0; recv_idle_pct = 0; end
                endcase
                @(posedge i_clk);
                // offset writes carry junk in the upper byte, which must be dropped
                case (seg % 5)
                    0: begin
                        write_reg(lbsp_pkg::CFG_GAIN, 16'hFFFF);
                        write_reg(lbsp_pkg::CFG_OFFSET, 16'hFFFF);
                        write_reg(lbsp_pkg::CFG_CAP, 16'hFFFF);
                    end
                    1: begin
                        write_reg(lbsp_pkg::CFG_GAIN, 16'h0000);
                        write_reg(lbsp_pkg::CFG_OFFSET, {8'($urandom), 8'hFF});
                        write_reg(lbsp_pkg::CFG_CAP, 16'h0000);
                    end
                    2: begin
                        write_reg(lbsp_pkg::CFG_GAIN, 16'($urandom_range(1, 600)));
                        write_reg(lbsp_pkg::CFG_OFFSET,
                                  {8'($urandom), 8'($urandom_range(1, 255))});
                        write_reg(lbsp_pkg::CFG_CAP, 16'hFFFF);
                    end
                    3: begin
                        write_reg(lbsp_pkg::CFG_GAIN, 16'd3060);
                        write_reg(lbsp_pkg::CFG_OFFSET, {8'($urandom), 8'h00});
                        write_reg(lbsp_pkg::CFG_CAP, 16'd1020);
                    end
                    default: begin
                        write_reg(lbsp_pkg::CFG_GAIN, 16'($urandom));
                        write_reg(lbsp_pkg::CFG_OFFSET, 16'($urandom));
                        write_reg(lbsp_pkg::CFG_CAP, 16'($urandom_range(0, 4000)));
                    end
                endcase
                write_reg(CFG_SPARE, 16'($urandom));
                i_cfg_we <= 1'b0;
                settings_done++;
                @(negedge i_clk);

                fed = 0;
                while (fed < 45) begin
                    kind = $urandom_range(0, 9);
                    len = (kind < 7) ? $urandom_range(1, 70) : $urandom_range(1, 30);
                    for (j = 0; j < len; j++)
                        queue_bin(rand_mag(),
                                  (kind < 7) ? (j == 0) : ($urandom_range(0, 7) == 0));
                    fed += len;
                end
            end
        end

        wait_for_drain();
        $display("Run covered %0d bins and %0d band words over %0d register settings",
                 bins_sent, bands_seen, settings_done + 1);
        $display("with sender and receiver stalls mixed both ways and a stall-free stretch");
        if (fault_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #5000000;
        $display("Timeout with %0d band words still pending", band_wait_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
